// ----- src/stereo_channel_mixer_with_clip_core_assert.svh -----
// ----------------------------------------------------------------------------
// stereo channel mixer assertion macros
// immediate-style wrappers for concurrent checks on clk / arst_n
// ----------------------------------------------------------------------------
`ifndef STEREO_CHANNEL_MIXER_WITH_CLIP_CORE_ASSERT_SVH
`define STEREO_CHANNEL_MIXER_WITH_CLIP_CORE_ASSERT_SVH

// same-cycle implication
`define SCMC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/scmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scmc_pkg
// shared types, widths and constants of the stereo channel mixer
// ----------------------------------------------------------------------------
package scmc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W = 8;
	localparam int GAIN_W = 8;
	localparam int PAN_W = 11;
	localparam int SUM_W = 32;
	localparam int MUL_B_W = 12;
	localparam int PROD_W = SUM_W + MUL_B_W;
	localparam int SCALE_W = 20;
	localparam int UNITY_SHIFT = 7;
	localparam int REG_DATA_W = 8;
	localparam int REG_IDX_W = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic signed [MUL_B_W-1:0] PAN_FULL = 12'sd128;

	localparam logic signed [SUM_W-1:0] CLIP_MAX16 = 32'sd32767;
	localparam logic signed [SUM_W-1:0] CLIP_MIN16 = -32'sd32768;
	localparam logic signed [SUM_W-1:0] CLIP_875_LIM = 32'(32768 * 875 / 1000);
	localparam logic signed [SUM_W-1:0] CLIP_75_LIM = 32'(32768 * 75 / 100);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MASTER = 2'd0,
		REG_BOOST  = 2'd1,
		REG_CLIP   = 2'd2,
		REG_MUTE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CLIP_MODE_NONE = 3'd0,
		CLIP_MODE_FULL = 3'd1,
		CLIP_MODE_875  = 3'd2,
		CLIP_MODE_75   = 3'd3
	} clip_mode_t;

	typedef struct packed {
		logic [7:0] master_volume;
		logic [2:0] boost_shift;
		clip_mode_t clip_mode;
		logic       mute;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [LEVEL_W-1:0]         level;
		logic [GAIN_W-1:0]          gain;
		logic [PAN_W-1:0]           pan;
		logic                       active;
		logic                       last_channel;
	} item_t;

endpackage
`default_nettype wire

// ----- src/scmc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_channel_mixer_with_clip_core_assert.svh"
// ----------------------------------------------------------------------------
// scmc_front
// input acceptance, drops inactive non-final words, queues the rest
// ----------------------------------------------------------------------------
module scmc_front #(
	parameter int DEPTH = scmc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire scmc_pkg::item_t   in_item,
	output scmc_pkg::item_t        head,
	output logic                   q_valid,
	input  wire logic              pop
);
	import scmc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           accept;
	logic           keep;
	logic           push;

	assign in_stall = (count_q == CW'(DEPTH));
	assign accept = in_valid && !in_stall;
	// inactive words that close no frame change nothing downstream
	assign keep = in_item.active || in_item.last_channel;
	assign push = accept && keep;
	assign q_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SCMC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count over depth")
	`SCMC_ASSERT_IMPL(a_no_pop_empty, pop, count_q != '0, "pop from empty queue")
	`SCMC_ASSERT_NEXT(a_drop_holds, accept && !keep && !pop, $stable(count_q), "dropped word queued")

endmodule
`default_nettype wire

// ----- src/scmc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_channel_mixer_with_clip_core_assert.svh"
// ----------------------------------------------------------------------------
// scmc_back
// mixing sequencer around one shared multiplier, frame finish and output reg
// ----------------------------------------------------------------------------
module scmc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scmc_pkg::item_t     head,
	input  wire logic                q_valid,
	output logic                     pop,
	input  wire scmc_pkg::cfg_t      cfg,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       left,
	output logic signed [31:0]       right
);
	import scmc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_GAIN  = 7'b0000010,
		ST_RIGHT = 7'b0000100,
		ST_LEFT  = 7'b0001000,
		ST_FIN_L = 7'b0010000,
		ST_FIN_R = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic signed [SCALE_W-1:0]  s_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [PAN_W-1:0]           pan_q;
	logic                       last_q;
	logic signed [SUM_W-1:0]    left_sum_q;
	logic signed [SUM_W-1:0]    right_sum_q;
	logic [SUM_W-1:0]           fin_q;
	logic signed [SUM_W-1:0]    lft_q;
	logic                       out_valid_q;
	logic signed [SUM_W-1:0]    left_q;
	logic signed [SUM_W-1:0]    right_q;

	logic signed [SUM_W-1:0]    mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SCALE_W-1:0]  scaled;
	logic signed [SUM_W-1:0]    pan_part;
	logic                       emit_ok;
	logic                       emit;
	logic                       in_finish;
	logic                       sums_clear;

	function automatic logic signed [SUM_W-1:0] finish_fn(input logic [SUM_W-1:0] v,
			input cfg_t c);
		logic signed [SUM_W-1:0] sh;
		logic signed [SUM_W-1:0] res;
		sh = $signed(v) >>> (3'(UNITY_SHIFT) - c.boost_shift);
		res = sh;
		case (c.clip_mode)
			CLIP_MODE_FULL: begin
				if (sh < CLIP_MIN16) res = CLIP_MIN16;
				else if (sh > CLIP_MAX16) res = CLIP_MAX16;
			end
			CLIP_MODE_875: begin
				if (sh < -CLIP_875_LIM) res = -CLIP_875_LIM;
				else if (sh > CLIP_875_LIM) res = CLIP_875_LIM;
			end
			CLIP_MODE_75: begin
				if (sh < -CLIP_75_LIM) res = -CLIP_75_LIM;
				else if (sh > CLIP_75_LIM) res = CLIP_75_LIM;
			end
			default: res = sh;
		endcase
		if (c.mute) begin
			res = '0;
		end
		return res;
	endfunction

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				mul_a = SUM_W'(head.sample);
				mul_b = $signed({4'b0, head.level});
			end
			ST_GAIN: begin
				mul_a = SUM_W'(s_q);
				mul_b = $signed({4'b0, gain_q});
			end
			ST_RIGHT: begin
				mul_a = SUM_W'(s_q);
				mul_b = $signed({1'b0, pan_q});
			end
			ST_LEFT: begin
				mul_a = SUM_W'(s_q);
				mul_b = PAN_FULL - $signed({1'b0, pan_q});
			end
			ST_FIN_L: begin
				mul_a = left_sum_q;
				mul_b = $signed({4'b0, cfg.master_volume});
			end
			ST_FIN_R: begin
				mul_a = right_sum_q;
				mul_b = $signed({4'b0, cfg.master_volume});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign scaled = prod[SCALE_W+UNITY_SHIFT-1:UNITY_SHIFT];
	assign pan_part = SUM_W'($signed(prod[SUM_W-1:UNITY_SHIFT]));
	assign pop = (state_q == ST_IDLE) && q_valid;
	assign emit_ok = !out_valid_q || !out_stall;
	assign emit = (state_q == ST_DONE) && emit_ok;
	assign in_finish = (state_q == ST_FIN_L) || (state_q == ST_FIN_R);
	assign sums_clear = (left_sum_q == '0) && (right_sum_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_sum_q <= '0;
			right_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						// queued inactive words always close a frame
						state_q <= head.active ? ST_GAIN : ST_FIN_L;
					end
				end
				ST_GAIN: state_q <= ST_RIGHT;
				ST_RIGHT: begin
					right_sum_q <= right_sum_q + pan_part;
					state_q <= ST_LEFT;
				end
				ST_LEFT: begin
					left_sum_q <= left_sum_q + pan_part;
					state_q <= last_q ? ST_FIN_L : ST_IDLE;
				end
				ST_FIN_L: state_q <= ST_FIN_R;
				ST_FIN_R: state_q <= ST_DONE;
				ST_DONE: begin
					if (emit_ok) begin
						left_sum_q <= '0;
						right_sum_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					s_q <= scaled;
					gain_q <= head.gain;
					pan_q <= head.pan;
					last_q <= head.last_channel;
				end
			end
			ST_GAIN: s_q <= scaled;
			ST_FIN_L: fin_q <= prod[SUM_W-1:0];
			ST_FIN_R: begin
				lft_q <= finish_fn(fin_q, cfg);
				fin_q <= prod[SUM_W-1:0];
			end
			ST_DONE: begin
				if (emit_ok) begin
					left_q <= lft_q;
					right_q <= finish_fn(fin_q, cfg);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign left = left_q;
	assign right = right_q;

	`SCMC_ASSERT_NEXT(a_emit_clears, emit, out_valid_q && sums_clear, "emit did not clear sums")
	`SCMC_ASSERT_NEXT(a_mix_returns, state_q == ST_LEFT && !last_q, state_q == ST_IDLE, "mix stuck")
	`SCMC_ASSERT_IMPL(a_valid_done, $rose(out_valid_q), $past(state_q == ST_DONE), "stray result")
	`SCMC_ASSERT_NEXT(a_sums_hold, in_finish, $stable({left_sum_q, right_sum_q}), "sums moved")

endmodule
`default_nettype wire

// ----- src/stereo_channel_mixer_with_clip_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// an active word runs through the multiplier steps level, gain, right pan and left
//   pan; a final word then runs through finish left, finish right and done, where
//   the result waits while the output is stalled; an inactive final word skips to
//   finish; all steps share the single multiplier, so new words wait for idle
// inactive non-final words are dropped at one per cycle while the queue has room
// reset: asynchronous, clears sums, config registers, queue and output valid
// ----------------------------------------------------------------------------
// stereo_channel_mixer_with_clip_core
// per-channel level/gain/pan mixing into stereo sums with master and clip
// ----------------------------------------------------------------------------
module stereo_channel_mixer_with_clip_core #(
	parameter int QUEUE_DEPTH = scmc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [scmc_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [scmc_pkg::LEVEL_W-1:0]         level,
	input  wire logic [scmc_pkg::GAIN_W-1:0]          gain,
	input  wire logic [scmc_pkg::PAN_W-1:0]           pan,
	input  wire logic                                 active,
	input  wire logic                                 last_channel,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [scmc_pkg::SUM_W-1:0]         left,
	output logic signed [scmc_pkg::SUM_W-1:0]         right,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [scmc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [scmc_pkg::REG_DATA_W-1:0]      cfg_data
);
	import scmc_pkg::*;

	cfg_t   cfg_q;
	item_t  in_item;
	item_t  head;
	logic   q_valid;
	logic   pop;

	assign in_item.sample = sample;
	assign in_item.level = level;
	assign in_item.gain = gain;
	assign in_item.pan = pan;
	assign in_item.active = active;
	assign in_item.last_channel = last_channel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_volume <= '0;
			cfg_q.boost_shift <= '0;
			cfg_q.clip_mode <= CLIP_MODE_NONE;
			cfg_q.mute <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MASTER: cfg_q.master_volume <= cfg_data;
				REG_BOOST: cfg_q.boost_shift <= cfg_data[2:0];
				REG_CLIP: cfg_q.clip_mode <= clip_mode_t'(cfg_data[2:0]);
				REG_MUTE: cfg_q.mute <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	scmc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.head    (head),
		.q_valid (q_valid),
		.pop     (pop)
	);

	scmc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_valid  (q_valid),
		.pop      (pop),
		.cfg      (cfg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left     (left),
		.right    (right)
	);

endmodule
`default_nettype wire
